// ===== sv/binr_pkg.sv =====
// ----------------------------------------------------------------------------
// binr_pkg: shared types, constants and helpers
// Sizes, item and register layouts and the window rank test used by the
// binarize and 3x3 rank erosion core.
// ----------------------------------------------------------------------------
package binr_pkg;

    // largest frame the line store and counters are built for
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    // fixed field widths
    localparam int CHAN_W     = 8;
    localparam int MIN_NB_W   = 4;
    localparam int CFG_SIZE_W = 11;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;
    localparam int WIN_W      = 9;
    localparam int CNT_W      = 4;

    // derived widths
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT + 3);
    localparam int WID_W  = $clog2(MAX_WIDTH + 1);
    localparam int DIM_A  = (WID_W > ROW_W) ? WID_W : ROW_W;
    localparam int DIM_W  = (DIM_A > CFG_SIZE_W) ? DIM_A : CFG_SIZE_W;

    localparam int MIN_DIM = 3;

    // task queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // item modes
    localparam logic MODE_PIXEL = 1'b0;
    localparam logic MODE_FLUSH = 1'b1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_THR_RED   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THR_GREEN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_THR_BLUE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_NB    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT    = 3'd5;

    // register reset values
    localparam logic [CHAN_W-1:0]     RST_THR_RED   = 8'h0F;
    localparam logic [CHAN_W-1:0]     RST_THR_GREEN = 8'h11;
    localparam logic [CHAN_W-1:0]     RST_THR_BLUE  = 8'h11;
    localparam logic [MIN_NB_W-1:0]   RST_MIN_NB    = 4'd6;
    localparam logic [CFG_SIZE_W-1:0] RST_WIDTH     = 11'd1024;
    localparam logic [CFG_SIZE_W-1:0] RST_HEIGHT    = 11'd1024;

    typedef struct packed {
        logic [CHAN_W-1:0]     thr_red;
        logic [CHAN_W-1:0]     thr_green;
        logic [CHAN_W-1:0]     thr_blue;
        logic [MIN_NB_W-1:0]   min_nb;
        logic [CFG_SIZE_W-1:0] width;
        logic [CFG_SIZE_W-1:0] height;
    } t_cfg;

    // one classified item on its way to the back end
    typedef struct packed {
        logic             is_last;   // frame closing item, no window update
        logic             bot;       // binarized new pixel, bottom of column
        logic             ge1;       // row at or below 1: middle row valid
        logic             ge2;       // row at or below 2: upper row valid
        logic [COL_W-1:0] col;
    } t_task;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

    function automatic logic [DIM_W-1:0] clamp_dim(
        input logic [CFG_SIZE_W-1:0] v,
        input logic [DIM_W-1:0]      hi
    );
        logic [DIM_W-1:0] ext;
        ext = DIM_W'(v);
        if (ext < DIM_W'(MIN_DIM)) begin
            return DIM_W'(MIN_DIM);
        end
        if (ext > hi) begin
            return hi;
        end
        return ext;
    endfunction

    // centre white and enough white bits in the window
    function automatic logic erode_window(
        input logic [WIN_W-1:0]    win,
        input logic [MIN_NB_W-1:0] min_nb
    );
        logic [CNT_W-1:0] count;
        count = '0;
        for (int i = 0; i < WIN_W; i++) begin
            count = count + CNT_W'(win[i]);
        end
        return win[4] && (count >= CNT_W'(min_nb));
    endfunction

endpackage

// ===== sv/binr_if.sv =====
// ----------------------------------------------------------------------------
// binr channel interfaces
// Pixel input, result output and register write channels.
// ----------------------------------------------------------------------------
interface binr_pix_if import binr_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              mode;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;

    modport source(output valid, mode, red, green, blue, input ready);
    modport sink(input valid, mode, red, green, blue, output ready);
endinterface

interface binr_res_if import binr_pkg::*; ();
    logic valid;
    logic ready;
    logic pixel_white;
    logic frame_last;

    modport source(output valid, pixel_white, frame_last, input ready);
    modport sink(input valid, pixel_white, frame_last, output ready);
endinterface

interface binr_cfg_if import binr_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

// ===== sv/binr_front.sv =====
// ----------------------------------------------------------------------------
// binr_front: pixel intake and classification
// Tracks the raster position, binarizes the pixel and pushes a task beat.
// ----------------------------------------------------------------------------
module binr_front import binr_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_busy,
    input  t_q_status  i_q_status,
    binr_pix_if.sink   i_pix,
    output logic       o_push,
    output t_task      o_task
);

    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;

    logic [DIM_W-1:0] w, h, x_inc;
    logic [COL_W-1:0] x;
    logic [ROW_W-1:0] y;
    logic             wrap, is_last, in_img, lit;

    always_comb begin
        w     = clamp_dim(i_cfg.width, DIM_W'(MAX_WIDTH));
        h     = clamp_dim(i_cfg.height, DIM_W'(MAX_HEIGHT));

        // a column beyond a shrunk width starts the next row
        wrap  = DIM_W'(r_col) >= w;
        x     = wrap ? '0 : r_col;
        y     = wrap ? r_row + ROW_W'(1) : r_row;

        is_last = DIM_W'(y) > h;
        in_img  = DIM_W'(y) < h;
        lit     = (i_pix.red >= i_cfg.thr_red) || (i_pix.green >= i_cfg.thr_green)
                  || (i_pix.blue >= i_cfg.thr_blue);

        o_task.is_last = is_last;
        o_task.bot     = !is_last && in_img && (i_pix.mode == MODE_PIXEL) && lit;
        o_task.ge1     = y != '0;
        o_task.ge2     = y >= ROW_W'(2);
        o_task.col     = x;

        x_inc = DIM_W'(x) + DIM_W'(1);
        if (is_last) begin
            n_col = '0;
            n_row = '0;
        end else if (x_inc >= w) begin
            n_col = '0;
            n_row = y + ROW_W'(1);
        end else begin
            n_col = x_inc[COL_W-1:0];
            n_row = y;
        end
    end

    assign i_pix.ready = !i_busy && !i_q_status.full;
    assign o_push      = i_pix.valid && i_pix.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (o_push) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

endmodule

// ===== sv/binr_queue.sv =====
// ----------------------------------------------------------------------------
// binr_queue: task queue
// Short first-in first-out buffer between the front and back ends.
// ----------------------------------------------------------------------------
module binr_queue import binr_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_task     i_task,
    input  logic      i_pop,
    output t_task     o_head,
    output t_q_status o_status
);

    t_task             r_buf [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    assign o_head          = r_buf[r_rd_ptr];
    assign o_status.empty  = r_count == '0;
    assign o_status.full   = r_count == QCNT_W'(QUEUE_DEPTH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wr_ptr] <= i_task;
        end
    end

endmodule

// ===== sv/binr_back.sv =====
// ----------------------------------------------------------------------------
// binr_back: line store, window and rank erosion
// Reads the two stored rows, shifts the 3x3 window and registers results.
// ----------------------------------------------------------------------------
module binr_back import binr_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [MIN_NB_W-1:0] i_min_nb,
    input  t_task               i_q_head,
    input  t_q_status           i_q_status,
    output logic                o_q_pop,
    output logic                o_busy,
    binr_res_if.source          o_res
);

    // entry bit 0: upper row, bit 1: middle row
    logic [1:0]       r_mem [MAX_WIDTH];

    logic             r_clr_busy;
    logic [COL_W-1:0] r_clr_addr;

    logic             r_a_valid;
    t_task            r_a_task;
    logic [1:0]       r_a_rd;
    logic [WIN_W-1:0] r_win, n_win;

    logic             r_o_valid, r_o_white, r_o_last;
    logic             n_white, n_last;

    logic             a_x0, a_emit, a_adv, a_free, out_free, top, mid;
    logic [WIN_W-1:0] shifted, old_shift;

    always_comb begin
        a_x0      = r_a_task.col == '0;
        top       = r_a_task.ge2 & r_a_rd[0];
        mid       = r_a_task.ge1 & r_a_rd[1];
        shifted   = {r_a_task.bot, mid, top,
                     a_x0 ? (WIN_W-3)'(0) : r_win[WIN_W-1:3]};
        old_shift = {3'b000, r_win[WIN_W-1:3]};

        if (r_a_task.is_last) begin
            a_emit  = 1'b1;
            n_white = erode_window(old_shift, i_min_nb);
            n_last  = 1'b1;
            n_win   = '0;
        end else begin
            // row start closes the previous row's last centre
            a_emit  = a_x0 ? r_a_task.ge2 : r_a_task.ge1;
            n_white = a_x0 ? erode_window(old_shift, i_min_nb)
                           : erode_window(shifted, i_min_nb);
            n_last  = 1'b0;
            n_win   = shifted;
        end

        out_free = !r_o_valid || o_res.ready;
        a_adv    = r_a_valid && (!a_emit || out_free);
        a_free   = !r_a_valid || a_adv;
        o_q_pop  = a_free && !i_q_status.empty && !r_clr_busy;
    end

    assign o_busy            = r_clr_busy;
    assign o_res.valid       = r_o_valid;
    assign o_res.pixel_white = r_o_white;
    assign o_res.frame_last  = r_o_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
            r_a_valid  <= 1'b0;
            r_win      <= '0;
            r_o_valid  <= 1'b0;
        end else begin
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + COL_W'(1);
                if (r_clr_addr == COL_W'(MAX_WIDTH - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end
            if (a_free) begin
                r_a_valid <= o_q_pop;
            end
            if (a_adv) begin
                r_win <= n_win;
            end
            if (a_adv && a_emit) begin
                r_o_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // line store: read on pop, written when the item leaves stage a
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_a_task <= i_q_head;
            r_a_rd   <= r_mem[i_q_head.col];
        end
        if (r_clr_busy) begin
            r_mem[r_clr_addr] <= 2'b00;
        end else if (a_adv && !r_a_task.is_last) begin
            r_mem[r_a_task.col] <= {r_a_task.bot, mid};
        end
        if (a_adv && a_emit) begin
            r_o_white <= n_white;
            r_o_last  <= n_last;
        end
    end

endmodule

// ===== sv/binarize_and_rank_erode_3x3_core.sv =====
// ----------------------------------------------------------------------------
// binarize_and_rank_erode_3x3_core: threshold binarization and 3x3 erosion
// Thresholds rgb pixels to one bit and keeps a white centre only when
// enough bits of its 3x3 neighbourhood are white.
// ----------------------------------------------------------------------------
// path: task queue, stage a, output register; results trail the pixel
//   stream by one row plus one pixel
// throughput: one beat per cycle while not clearing and the queue has room
//   (set by the single line store port pair); reset: synchronous, registers
//   take their reset values, then a clearing pass zeroes the line store with input ready low
module binarize_and_rank_erode_3x3_core import binr_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    binr_cfg_if.sink   i_cfg,
    binr_pix_if.sink   i_pix,
    binr_res_if.source o_res
);

    // configuration registers
    t_cfg r_cfg;

    // front to queue
    logic      push;
    t_task     push_task;

    // queue to back
    logic      pop;
    t_task     q_head;
    t_q_status q_status;

    // line store clearing pass in progress
    logic      busy;

    // register writes always taken; user writes only while block idle, not enforced
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.thr_red   <= RST_THR_RED;
            r_cfg.thr_green <= RST_THR_GREEN;
            r_cfg.thr_blue  <= RST_THR_BLUE;
            r_cfg.min_nb    <= RST_MIN_NB;
            r_cfg.width     <= RST_WIDTH;
            r_cfg.height    <= RST_HEIGHT;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_THR_RED:   r_cfg.thr_red   <= i_cfg.data[CHAN_W-1:0];
                REG_THR_GREEN: r_cfg.thr_green <= i_cfg.data[CHAN_W-1:0];
                REG_THR_BLUE:  r_cfg.thr_blue  <= i_cfg.data[CHAN_W-1:0];
                REG_MIN_NB:    r_cfg.min_nb    <= i_cfg.data[MIN_NB_W-1:0];
                REG_WIDTH:     r_cfg.width     <= i_cfg.data[CFG_SIZE_W-1:0];
                REG_HEIGHT:    r_cfg.height    <= i_cfg.data[CFG_SIZE_W-1:0];
                default: begin
                    // unused index, write dropped
                end
            endcase
        end
    end

    // front: raster position, binarize, classify, push one task per beat
    binr_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_busy     (busy),
        .i_q_status (q_status),
        .i_pix      (i_pix),
        .o_push     (push),
        .o_task     (push_task)
    );

    // queue decouples intake from the result side stalls
    binr_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_task   (push_task),
        .i_pop    (pop),
        .o_head   (q_head),
        .o_status (q_status)
    );

    // back: line store, window shift, rank test, output register
    binr_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_min_nb   (r_cfg.min_nb),
        .i_q_head   (q_head),
        .i_q_status (q_status),
        .o_q_pop    (pop),
        .o_busy     (busy),
        .o_res      (o_res)
    );

endmodule

// ===== tb/sv/tb_binarize_and_rank_erode_3x3_core.sv =====
// ----------------------------------------------------------------------------
// tb_binarize_and_rank_erode_3x3_core: self-checking bench for the erosion core
// Streams rgb pixel beats through the core. A behavioral copy of the
// thresholding, window, line stores and frame counting predicts each result
// beat, and every result beat is checked against the oldest prediction.
// A short table of hand-picked beats comes first, then phases of random frames
// under changing register settings, with random stalls on both channels.
// ----------------------------------------------------------------------------
module tb_binarize_and_rank_erode_3x3_core;
    import binr_pkg::*;

    localparam int CLK_PERIOD     = 12;
    localparam int RESET_CYCLES   = 11;
    localparam int SETTLE_CYCLES  = 8;
    localparam int DRAIN_LIMIT    = 50_000;
    localparam int RX_HOLD_CYCLES = 400;     // long output stall, fills the core
    localparam int RANDOM_ITEMS   = 200;
    localparam int CALM_ITEMS     = 60;      // closing stretch without idling
    localparam int TIMEOUT_CYCLES = 800_000;

    // index values the core does not map; writes to them must change nothing
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = 3'd7;

    // how a directed beat's result is judged
    typedef enum logic [1:0] {
        EXP_MODEL,        // whatever the predictor says
        EXP_NONE,         // no result beat
        EXP_BLACK,        // black pixel, not last
        EXP_BLACK_LAST    // black pixel closing the frame
    } exp_kind_e;

    typedef struct packed {
        logic pixel_white;
        logic frame_last;
    } erode_res_t;

    typedef struct {
        logic              mode;
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        exp_kind_e         kind;
    } probe_row_t;

    logic i_clk;
    logic i_rst_n;

    binr_cfg_if cfg_if();
    binr_pix_if pix_if();
    binr_res_if res_if();

    binarize_and_rank_erode_3x3_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_if),
        .i_pix   (pix_if),
        .o_res   (res_if)
    );

    // ------------------------------------------------------------------------
    // shadow of the core: registers, line stores, window and frame position
    // ------------------------------------------------------------------------
    t_cfg             model_cfg = '{thr_red: RST_THR_RED, thr_green: RST_THR_GREEN,
                                    thr_blue: RST_THR_BLUE, min_nb: RST_MIN_NB,
                                    width: RST_WIDTH, height: RST_HEIGHT};
    bit               upper_row  [MAX_WIDTH];
    bit               middle_row [MAX_WIDTH];
    logic [WIN_W-1:0] win_bits = '0;
    int unsigned      pos_col  = 0;
    int unsigned      pos_row  = 0;

    // predicted result beats, oldest first
    erode_res_t erode_expected[$];

    int error_count = 0;
    bit tx_idle_en  = 1'b0;
    bit rx_idle_en  = 1'b0;
    bit rx_hold_req = 1'b0;

    // every index the config port can carry, mapped ones by name
    logic [CFG_IDX_W-1:0] reg_write_order [8] = '{
        REG_THR_RED, REG_THR_GREEN, REG_THR_BLUE, REG_MIN_NB,
        REG_WIDTH, REG_HEIGHT, REG_UNMAPPED_LO, REG_UNMAPPED_HI
    };

    // hand-picked beats at w=3, h=3, default thresholds and min_nb
    probe_row_t probe_tbl [26] = '{
        // frame of black only: levels one under threshold, flush and
        // pixel-in-flush-row both black, so every result is plainly black
        '{MODE_PIXEL, 8'd0,   8'd0,   8'd0,   EXP_NONE},
        '{MODE_PIXEL, 8'd14,  8'd16,  8'd16,  EXP_NONE},
        '{MODE_FLUSH, 8'd255, 8'd255, 8'd255, EXP_NONE},
        '{MODE_PIXEL, 8'd14,  8'd16,  8'd16,  EXP_NONE},
        '{MODE_PIXEL, 8'd0,   8'd0,   8'd0,   EXP_BLACK},
        '{MODE_PIXEL, 8'd14,  8'd0,   8'd16,  EXP_BLACK},
        '{MODE_PIXEL, 8'd0,   8'd16,  8'd0,   EXP_BLACK},
        '{MODE_PIXEL, 8'd14,  8'd16,  8'd16,  EXP_BLACK},
        '{MODE_FLUSH, 8'd255, 8'd0,   8'd0,   EXP_BLACK},
        '{MODE_PIXEL, 8'd255, 8'd255, 8'd255, EXP_BLACK},
        '{MODE_FLUSH, 8'd0,   8'd0,   8'd0,   EXP_BLACK},
        '{MODE_FLUSH, 8'd0,   8'd0,   8'd0,   EXP_BLACK},
        '{MODE_FLUSH, 8'd0,   8'd0,   8'd0,   EXP_BLACK_LAST},
        // mixed frame: each channel exactly at its threshold, full scale,
        // flush inside the image, a bright pixel in the flush row
        '{MODE_PIXEL, 8'd15,  8'd0,   8'd0,   EXP_MODEL},
        '{MODE_PIXEL, 8'd0,   8'd17,  8'd0,   EXP_MODEL},
        '{MODE_PIXEL, 8'd0,   8'd0,   8'd17,  EXP_MODEL},
        '{MODE_PIXEL, 8'd255, 8'd255, 8'd255, EXP_MODEL},
        '{MODE_FLUSH, 8'd255, 8'd255, 8'd255, EXP_MODEL},
        '{MODE_PIXEL, 8'd255, 8'd0,   8'd0,   EXP_MODEL},
        '{MODE_PIXEL, 8'd0,   8'd255, 8'd0,   EXP_MODEL},
        '{MODE_PIXEL, 8'd0,   8'd0,   8'd255, EXP_MODEL},
        '{MODE_PIXEL, 8'd16,  8'd18,  8'd18,  EXP_MODEL},
        '{MODE_PIXEL, 8'd255, 8'd255, 8'd255, EXP_MODEL},
        '{MODE_FLUSH, 8'd0,   8'd0,   8'd0,   EXP_MODEL},
        '{MODE_FLUSH, 8'd0,   8'd0,   8'd0,   EXP_MODEL},
        '{MODE_FLUSH, 8'd0,   8'd0,   8'd0,   EXP_MODEL}
    };

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------

    // sizes outside 3 .. max are pinned when used
    function automatic int unsigned fit_dim(input logic [CFG_SIZE_W-1:0] v,
                                            input int unsigned hi);
        if (v < 3) return 3;
        if (v > hi) return hi;
        return 32'(v);
    endfunction

    // centre (bit 4) must be white and the window must hold enough white bits
    function automatic logic rank_keep(input logic [WIN_W-1:0] win);
        return win[4] && ($countones(win) >= int'(model_cfg.min_nb));
    endfunction

    function automatic t_cfg make_cfg(input logic [CHAN_W-1:0] thr_r, thr_g, thr_b,
                                      input logic [MIN_NB_W-1:0] nb,
                                      input logic [CFG_SIZE_W-1:0] w, h);
        t_cfg c;
        c.thr_red   = thr_r;
        c.thr_green = thr_g;
        c.thr_blue  = thr_b;
        c.min_nb    = nb;
        c.width     = w;
        c.height    = h;
        return c;
    endfunction

    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] d);
        case (idx)
            REG_THR_RED:   model_cfg.thr_red   = d[CHAN_W-1:0];
            REG_THR_GREEN: model_cfg.thr_green = d[CHAN_W-1:0];
            REG_THR_BLUE:  model_cfg.thr_blue  = d[CHAN_W-1:0];
            REG_MIN_NB:    model_cfg.min_nb    = d[MIN_NB_W-1:0];
            REG_WIDTH:     model_cfg.width     = d[CFG_SIZE_W-1:0];
            REG_HEIGHT:    model_cfg.height    = d[CFG_SIZE_W-1:0];
            default: ;
        endcase
    endfunction

    // true when the next beat lands on a row inside the image
    function automatic bit next_in_image();
        int unsigned w;
        int unsigned h;
        int unsigned row;
        w   = fit_dim(model_cfg.width, MAX_WIDTH);
        h   = fit_dim(model_cfg.height, MAX_HEIGHT);
        row = (pos_col >= w) ? pos_row + 1 : pos_row;
        return row < h;
    endfunction

    // one accepted pixel beat; at most one result beat comes of it
    function automatic void erode_predict(input logic mode,
                                          input logic [CHAN_W-1:0] r, g, b,
                                          output bit has_res, output erode_res_t res);
        int unsigned w;
        int unsigned h;
        int unsigned x;
        int unsigned y;
        logic top;
        logic mid;
        logic bot;
        w       = fit_dim(model_cfg.width, MAX_WIDTH);
        h       = fit_dim(model_cfg.height, MAX_HEIGHT);
        has_res = 1'b0;
        res     = '0;
        // a width shrunk mid row pushes the position onto the next row
        if (pos_col >= w) begin
            pos_col = 0;
            pos_row++;
        end
        // past the flush row: bottom right result, frame restarts
        if (pos_row > h) begin
            res.pixel_white = rank_keep(win_bits >> 3);
            res.frame_last  = 1'b1;
            has_res  = 1'b1;
            win_bits = '0;
            pos_col  = 0;
            pos_row  = 0;
            return;
        end
        x = pos_col;
        y = pos_row;
        // new row: last centre of the row above goes out, window empties
        if (x == 0) begin
            if (y >= 2) begin
                res.pixel_white = rank_keep(win_bits >> 3);
                has_res = 1'b1;
            end
            win_bits = '0;
        end
        // rows above the image read black whatever the stores still hold
        top = (y >= 2) ? upper_row[x] : 1'b0;
        mid = (y >= 1) ? middle_row[x] : 1'b0;
        bot = (y < h) && (mode == MODE_PIXEL) &&
              (r >= model_cfg.thr_red || g >= model_cfg.thr_green ||
               b >= model_cfg.thr_blue);
        win_bits      = {bot, mid, top, win_bits[WIN_W-1:3]};
        upper_row[x]  = mid;
        middle_row[x] = bot;
        if (x >= 1 && y >= 1) begin
            res.pixel_white = rank_keep(win_bits);
            res.frame_last  = 1'b0;
            has_res = 1'b1;
        end
        x++;
        if (x >= w) begin
            x = 0;
            y++;
        end
        pos_col = x;
        pos_row = y;
    endfunction

    // ------------------------------------------------------------------------
    // clock, timeout
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // covers the line store clearing pass and worst case stalls many times over
    initial begin
        #(CLK_PERIOD * TIMEOUT_CYCLES);
        $display("tb_binarize_and_rank_erode_3x3_core failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // result side: ready with random stall bursts, and one long hold-off
    // ------------------------------------------------------------------------
    initial begin
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_hold_req) begin
                // long hold-off, the pixel side keeps pushing meanwhile
                rx_hold_req = 1'b0;
                res_if.ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge i_clk);
            end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
                res_if.ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge i_clk);
            end
            res_if.ready <= 1'b1;
        end
    end

    // every result beat is checked against the oldest prediction
    always @(posedge i_clk) begin : result_check
        erode_res_t want;
        if (i_rst_n === 1'b1 && res_if.valid && res_if.ready) begin
            if (erode_expected.size() == 0) begin
                $error("result beat with nothing expected: pixel_white %0b frame_last %0b",
                       res_if.pixel_white, res_if.frame_last);
                error_count++;
            end else begin
                want = erode_expected.pop_front();
                if (res_if.pixel_white !== want.pixel_white) begin
                    $error("pixel_white: expected %0b actual %0b",
                           want.pixel_white, res_if.pixel_white);
                    error_count++;
                end
                if (res_if.frame_last !== want.frame_last) begin
                    $error("frame_last: expected %0b actual %0b",
                           want.frame_last, res_if.frame_last);
                    error_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // pixel and register side
    // ------------------------------------------------------------------------

    // one pixel beat, optionally after a random gap; valid stays high after
    // the handshake, so back to back beats leave no gap in valid
    task automatic send_pixel(input logic mode, input logic [CHAN_W-1:0] r, g, b,
                              input exp_kind_e kind);
        bit         has_res;
        erode_res_t res;
        if (tx_idle_en && $urandom_range(0, 3) == 0) begin
            pix_if.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        pix_if.valid <= 1'b1;
        pix_if.mode  <= mode;
        pix_if.red   <= r;
        pix_if.green <= g;
        pix_if.blue  <= b;
        do @(posedge i_clk); while (!pix_if.ready);
        erode_predict(mode, r, g, b, has_res, res);
        case (kind)
            EXP_MODEL:      if (has_res) erode_expected.push_back(res);
            EXP_BLACK:      erode_expected.push_back('{pixel_white: 1'b0, frame_last: 1'b0});
            EXP_BLACK_LAST: erode_expected.push_back('{pixel_white: 1'b0, frame_last: 1'b1});
            default: ;
        endcase
    endtask

    // all predicted beats back, then a settling wait for beats that yield nothing
    task automatic wait_for_drain();
        int guard;
        guard = 0;
        pix_if.valid <= 1'b0;
        while (erode_expected.size() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // writes every index, unused upper data bits randomized; valid held high
    // across the whole burst
    task automatic program_regs(input t_cfg c);
        logic [CFG_DATA_W-1:0] d;
        foreach (reg_write_order[i]) begin
            case (reg_write_order[i])
                REG_THR_RED:   d = {3'($urandom), c.thr_red};
                REG_THR_GREEN: d = {3'($urandom), c.thr_green};
                REG_THR_BLUE:  d = {3'($urandom), c.thr_blue};
                REG_MIN_NB:    d = {7'($urandom), c.min_nb};
                REG_WIDTH:     d = c.width;
                REG_HEIGHT:    d = c.height;
                default:       d = CFG_DATA_W'($urandom);
            endcase
            cfg_if.valid <= 1'b1;
            cfg_if.index <= reg_write_order[i];
            cfg_if.data  <= d;
            do @(posedge i_clk); while (!cfg_if.ready);
            apply_reg(reg_write_order[i], d);
        end
        cfg_if.valid <= 1'b0;
    endtask

    // new settings once idle, then a run of beats; well formed runs follow
    // the frame (pixels in image rows, flush below) with a little noise;
    // the long output hold-off starts once the beats begin
    task automatic run_phase(input t_cfg c, input int n_items, input bit well_formed,
                             input int chan_max, input bit hold_rx = 1'b0);
        logic mode;
        wait_for_drain();
        program_regs(c);
        if (hold_rx) begin
            rx_hold_req = 1'b1;
        end
        repeat (n_items) begin
            if (well_formed && $urandom_range(0, 19) != 0) begin
                mode = next_in_image() ? MODE_PIXEL : MODE_FLUSH;
            end else begin
                mode = $urandom_range(0, 1) ? MODE_FLUSH : MODE_PIXEL;
            end
            send_pixel(mode, CHAN_W'($urandom_range(0, chan_max)),
                       CHAN_W'($urandom_range(0, chan_max)),
                       CHAN_W'($urandom_range(0, chan_max)), EXP_MODEL);
        end
    endtask

    initial begin : stimulus
        t_cfg c;
        int   n;
        int   random_items;
        bit   well;

        i_rst_n      <= 1'b0;
        pix_if.valid <= 1'b0;
        pix_if.mode  <= MODE_PIXEL;
        pix_if.red   <= '0;
        pix_if.green <= '0;
        pix_if.blue  <= '0;
        cfg_if.valid <= 1'b0;
        cfg_if.index <= REG_THR_RED;
        cfg_if.data  <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: sizes below the minimum pin to 3x3, default levels
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        program_regs(make_cfg(RST_THR_RED, RST_THR_GREEN, RST_THR_BLUE, RST_MIN_NB,
                              11'd2, 11'd0));
        foreach (probe_tbl[i]) begin
            send_pixel(probe_tbl[i].mode, probe_tbl[i].red, probe_tbl[i].green,
                       probe_tbl[i].blue, probe_tbl[i].kind);
        end

        // zero thresholds, min_nb zero: centre alone decides
        run_phase(make_cfg(8'd0, 8'd0, 8'd0, 4'd0, 11'd5, 11'd4), 2 * (5 * 5 + 1), 1'b1, 255);
        // top thresholds, min_nb above nine: all black
        run_phase(make_cfg(8'd255, 8'd255, 8'd255, 4'd15, 11'd7, 11'd3),
                  2 * (7 * 4 + 1), 1'b1, 255);
        // oversized width pins to the widest row; start of a frame only
        run_phase(make_cfg(8'd128, 8'd64, 8'd200, 4'd9, 11'd2047, 11'd3), 120, 1'b1, 255);
        // width shrinks mid row, then the top of the tallest frame at minimum
        // width; the output is held off for a long stretch so the core backs up
        tx_idle_en = 1'b0;
        run_phase(make_cfg(8'd40, 8'd40, 8'd40, 4'd1, 11'd3, 11'd1024),
                  120, 1'b1, 255, 1'b1);

        // random settings; many phases stop mid frame so the next settings
        // land inside a frame; the closing stretch runs without idling
        random_items = 0;
        while (random_items < RANDOM_ITEMS) begin
            tx_idle_en = (random_items < RANDOM_ITEMS - CALM_ITEMS) && $urandom_range(0, 3) != 0;
            rx_idle_en = (random_items < RANDOM_ITEMS - CALM_ITEMS) && $urandom_range(0, 3) != 0;
            c = make_cfg(CHAN_W'($urandom_range(0, 255)), CHAN_W'($urandom_range(0, 255)),
                         CHAN_W'($urandom_range(0, 255)),
                         ($urandom_range(0, 3) == 0) ? MIN_NB_W'($urandom_range(0, 15))
                                                     : MIN_NB_W'($urandom_range(1, 9)),
                         CFG_SIZE_W'($urandom_range(0, 10)),
                         CFG_SIZE_W'($urandom_range(0, 8)));
            well = $urandom_range(0, 3) != 0;
            if (well) begin
                n = $urandom_range(1, 2) * (fit_dim(c.width, MAX_WIDTH) *
                                            (fit_dim(c.height, MAX_HEIGHT) + 1) + 1);
            end else begin
                n = $urandom_range(1, 40);
            end
            run_phase(c, n, well, $urandom_range(0, 1) ? 255 : $urandom_range(0, 255));
            random_items += n;
        end

        // end of run: everything back, then a short settle for stray beats
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        wait_for_drain();
        if (erode_expected.size() != 0) begin
            $error("%0d expected result beats never arrived", erode_expected.size());
            error_count++;
        end
        if (error_count == 0) begin
            $display("tb_binarize_and_rank_erode_3x3_core passed");
        end else begin
            $display("tb_binarize_and_rank_erode_3x3_core failed");
        end
        $finish;
    end

endmodule
